[hw/rtl/assert_macros.svh]
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must never hold outside reset.
`define ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("never violated");

// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication violated");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

[hw/rtl/dqz_pkg.sv]
package dqz_pkg;

  typedef enum logic [2:0] {
    ST_COLLECT,
    ST_PASS1,
    ST_PASS2,
    ST_SCALE_U,
    ST_SCALE_V,
    ST_DIVIDE,
    ST_OUTPUT
  } state_t;

  localparam logic [6:0]  LEVEL_SHIFT = 7'd64;
  localparam logic [13:0] INV_SQRT2   = 14'd11585;

  localparam logic signed [15:0] COS_TAB [9] = '{
    16'sd16384, 16'sd16069, 16'sd15137, 16'sd13623, 16'sd11585,
    16'sd9102, 16'sd6270, 16'sd3196, 16'sd0
  };

  localparam logic [6:0] QUANT_LUMA [64] = '{
    7'd16, 7'd11, 7'd10, 7'd16, 7'd24, 7'd40, 7'd51, 7'd61,
    7'd12, 7'd12, 7'd14, 7'd19, 7'd26, 7'd58, 7'd60, 7'd55,
    7'd14, 7'd13, 7'd16, 7'd24, 7'd40, 7'd57, 7'd69, 7'd56,
    7'd14, 7'd17, 7'd22, 7'd29, 7'd51, 7'd87, 7'd80, 7'd62,
    7'd18, 7'd22, 7'd37, 7'd56, 7'd68, 7'd109, 7'd103, 7'd77,
    7'd24, 7'd35, 7'd55, 7'd64, 7'd81, 7'd104, 7'd113, 7'd92,
    7'd49, 7'd64, 7'd78, 7'd87, 7'd103, 7'd121, 7'd120, 7'd101,
    7'd72, 7'd92, 7'd95, 7'd98, 7'd112, 7'd100, 7'd103, 7'd99
  };

  localparam logic [6:0] QUANT_CHROMA [64] = '{
    7'd17, 7'd18, 7'd24, 7'd47, 7'd99, 7'd99, 7'd99, 7'd99,
    7'd18, 7'd21, 7'd26, 7'd66, 7'd99, 7'd99, 7'd99, 7'd99,
    7'd24, 7'd26, 7'd56, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
    7'd47, 7'd66, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
    7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
    7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
    7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
    7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99
  };

  localparam logic [5:0] ZIGZAG [64] = '{
    6'd0, 6'd1, 6'd8, 6'd16, 6'd9, 6'd2, 6'd3, 6'd10,
    6'd17, 6'd24, 6'd32, 6'd25, 6'd18, 6'd11, 6'd4, 6'd5,
    6'd12, 6'd19, 6'd26, 6'd33, 6'd40, 6'd48, 6'd41, 6'd34,
    6'd27, 6'd20, 6'd13, 6'd6, 6'd7, 6'd14, 6'd21, 6'd28,
    6'd35, 6'd42, 6'd49, 6'd56, 6'd57, 6'd50, 6'd43, 6'd36,
    6'd29, 6'd22, 6'd15, 6'd23, 6'd30, 6'd37, 6'd44, 6'd51,
    6'd58, 6'd59, 6'd52, 6'd45, 6'd38, 6'd31, 6'd39, 6'd46,
    6'd53, 6'd60, 6'd61, 6'd54, 6'd47, 6'd55, 6'd62, 6'd63
  };

  // Q14 cos((2*pos+1)*freq*pi/16)
  function automatic logic signed [15:0] basis(input logic [2:0] pos, input logic [2:0] freq);
    logic [6:0] k;
    logic [4:0] m;
    logic [3:0] i;
    k = 7'({pos, 1'b1}) * 7'(freq);
    m = k[4:0];
    if (m > 5'd16) m = 5'(6'd32 - {1'b0, m});
    if (m > 5'd8) begin
      i = {1'b0, 3'(5'd16 - m)};
      return -COS_TAB[i];
    end
    i = m[3:0];
    return COS_TAB[i];
  endfunction

endpackage

[hw/rtl/dqz_ram.sv]
module dqz_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

[hw/rtl/dct_quant_zigzag_8x8_top.sv]
// channel | signals                       | direction
// in      | in_valid in_ready pixel       | pixels, raster order
// out     | out_valid out_ready coefficient scan_position last_of_block | zigzag order
// cfg     | cfg_valid cfg_ready cfg_data  | table_select, always ready
//
// Pixels are taken one per cycle until 64 are stored; in_ready then drops.
// Row pass: one MAC accumulates each partial and writes it to the row RAM.
// Column pass: per coefficient a MAC, the SCALE_U and SCALE_V scale states, a
// bit-serial restoring divide, then the output register, which waits on out_ready.
// Synchronous reset clears control; the table in use is latched with pixel 64.
module dct_quant_zigzag_8x8_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  pixel,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [11:0] coefficient,
  output logic [5:0]  scan_position,
  output logic        last_of_block,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);
  import dqz_pkg::*;

  state_t state, state_next;

  logic       table_sel, table_use;
  logic [5:0] pix_cnt, xv, k;
  logic [3:0] step, dcnt;
  logic signed [24:0] acc1, acc1_next, prod1;
  logic signed [42:0] acc2, acc2_next;
  logic signed [40:0] prod2;
  logic signed [8:0]  pdiff;
  logic [41:0] mag, mag_abs, mag_src;
  logic [55:0] sprod;
  logic        neg;
  logic [11:0] dvd, quo, quo_next;
  logic [6:0]  rem, rem_next, qdiv;
  logic [7:0]  trial;
  logic        ge;
  logic [5:0]  idx;
  logic [2:0]  ym1;

  logic        pix_we;
  logic [5:0]  pix_raddr, row_raddr;
  logic [7:0]  pix_rdata;
  logic        row_we;
  logic [24:0] row_rdata;

  dqz_ram #(.WIDTH(8), .DEPTH(64)) u_pix_ram (
    .clk(clk), .we(pix_we), .waddr(pix_cnt), .wdata(pixel),
    .raddr(pix_raddr), .rdata(pix_rdata)
  );

  dqz_ram #(.WIDTH(25), .DEPTH(64)) u_row_ram (
    .clk(clk), .we(row_we), .waddr(xv), .wdata(acc1_next),
    .raddr(row_raddr), .rdata(row_rdata)
  );

  assign idx   = ZIGZAG[k];
  assign ym1   = 3'(step - 4'd1);
  assign pdiff = $signed({1'b0, pix_rdata}) - $signed({1'b0, LEVEL_SHIFT, 1'b0});
  assign prod1 = pdiff * basis(ym1, xv[2:0]);
  assign acc1_next = (step == 4'd1) ? prod1 : acc1 + prod1;
  assign prod2 = $signed(row_rdata) * basis(ym1, idx[2:0]);
  assign acc2_next = (step == 4'd1) ? 43'(prod2) : acc2 + 43'(prod2);
  assign mag_abs = acc2[42] ? 42'(-acc2) : acc2[41:0];
  assign mag_src = (state == ST_SCALE_U) ? mag_abs : mag;
  assign sprod   = 56'(mag_src) * 56'(INV_SQRT2);

  assign trial    = {rem, dvd[11]};
  assign ge       = trial >= {1'b0, qdiv};
  assign rem_next = ge ? 7'(trial - {1'b0, qdiv}) : trial[6:0];
  assign quo_next = {quo[10:0], ge};

  assign cfg_ready = 1'b1;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_COLLECT: if (in_valid && pix_cnt == 6'd63) state_next = ST_PASS1;
      ST_PASS1:   if (step == 4'd8 && xv == 6'd63) state_next = ST_PASS2;
      ST_PASS2:   if (step == 4'd8) state_next = ST_SCALE_U;
      ST_SCALE_U: state_next = ST_SCALE_V;
      ST_SCALE_V: state_next = ST_DIVIDE;
      ST_DIVIDE:  if (dcnt == 4'd11) state_next = ST_OUTPUT;
      ST_OUTPUT: begin
        if (out_ready) state_next = (k == 6'd63) ? ST_COLLECT : ST_PASS2;
      end
      default:    state_next = ST_COLLECT;
    endcase
  end

  // outputs and memory controls
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    pix_we    = 1'b0;
    row_we    = 1'b0;
    pix_raddr = {step[2:0], xv[5:3]};
    row_raddr = {step[2:0], idx[5:3]};
    case (state)
      ST_COLLECT: begin
        in_ready = 1'b1;
        pix_we   = in_valid;
      end
      ST_PASS1:  row_we    = (step == 4'd8);
      ST_OUTPUT: out_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_COLLECT;
      table_sel <= 1'b0;
      pix_cnt   <= '0;
      step      <= '0;
      xv        <= '0;
      k         <= '0;
      dcnt      <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid) table_sel <= cfg_data;
      case (state)
        ST_COLLECT: begin
          if (in_valid) begin
            pix_cnt <= pix_cnt + 6'd1;
            if (pix_cnt == 6'd63) begin
              table_use <= table_sel;
              step      <= '0;
              xv        <= '0;
            end
          end
        end
        ST_PASS1: begin
          acc1 <= acc1_next;
          if (step == 4'd8) begin
            step <= '0;
            xv   <= xv + 6'd1;
            if (xv == 6'd63) k <= '0;
          end else begin
            step <= step + 4'd1;
          end
        end
        ST_PASS2: begin
          acc2 <= acc2_next;
          step <= (step == 4'd8) ? 4'd0 : step + 4'd1;
        end
        ST_SCALE_U: begin
          neg <= acc2[42];
          mag <= (idx[2:0] == 3'd0) ? sprod[55:14] : mag_abs;
        end
        ST_SCALE_V: begin
          // drop the Q28 fraction (Q42 after the 1/sqrt2 scale) and the divide by 4
          dvd  <= (idx[5:3] == 3'd0) ? sprod[55:44] : mag[41:30];
          rem  <= '0;
          quo  <= '0;
          dcnt <= '0;
          qdiv <= table_use ? QUANT_CHROMA[idx] : QUANT_LUMA[idx];
        end
        ST_DIVIDE: begin
          rem  <= rem_next;
          quo  <= quo_next;
          dvd  <= {dvd[10:0], 1'b0};
          dcnt <= dcnt + 4'd1;
          if (dcnt == 4'd11) begin
            scan_position <= k;
            last_of_block <= (k == 6'd63);
            if (neg) coefficient <= $signed(12'(-quo_next));
            else if (quo_next[11]) coefficient <= 12'sd2047;
            else coefficient <= $signed(quo_next);
          end
        end
        ST_OUTPUT: if (out_ready) k <= k + 6'd1;
        default: ;
      endcase
    end
  end
endmodule

[hw/rtl/dqz_checker.sv]
module dqz_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic signed [11:0] coefficient,
  input logic [5:0]  scan_position,
  input logic        last_of_block
);
`include "assert_macros.svh"

  // input is never taken while a coefficient is on offer
  `ASSERT_NEVER(a_no_overlap, clk, rst, in_ready && out_valid)
  `ASSERT_IMPL(a_last_flag, clk, rst, out_valid, last_of_block == (scan_position == 6'd63))
  `ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(coefficient) && $stable(scan_position))
  `ASSERT_NEXT(a_block_end, clk, rst, out_valid && out_ready && last_of_block, in_ready && !out_valid)
endmodule

bind dct_quant_zigzag_8x8_top dqz_checker u_dqz_checker (.*);
